// ===== rtl/mst_pkg.sv =====
// Shared types and constants for the multi-slot software timer.
// Used by the channel interfaces, the slot table, the tick unit and the top level.
// Depends on nothing.
package mst_pkg;

  localparam int SLOTS     = 16;
  localparam int TICK_BITS = 32;
  localparam int SLOT_IW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam int ACTION_W = 2;
  localparam int SLOT_W   = 4;
  localparam int FIELD_W  = 32;

  localparam logic [ACTION_W-1:0] ACT_TICK = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_ARM  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_FREE = 2'd2;

  localparam logic KIND_FIRED = 1'b0;
  localparam logic KIND_DONE  = 1'b1;

  typedef logic [TICK_BITS-1:0] tick_t;
  typedef logic [SLOT_IW-1:0]   slot_idx_t;

  typedef struct packed {
    logic      cfg_en;
    logic      cnt_en;
    slot_idx_t addr;
    tick_t     delay;
    tick_t     interval;
    tick_t     count;
  } tbl_wr_t;

  typedef struct packed {
    tick_t delay;
    tick_t interval;
    tick_t count;
  } tbl_rd_t;

  typedef struct packed {
    logic  hit;
    tick_t count;
  } alu_res_t;

endpackage

// ===== rtl/mst_ifs.sv =====
// Valid/ready channel interfaces for the timer's request and result beats.
// Depends on mst_pkg for the field widths.
interface mst_in_if import mst_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [SLOT_W-1:0]   slot;
  logic [FIELD_W-1:0]  delay_ticks;
  logic [FIELD_W-1:0]  interval_ticks;
  logic                one_shot;
  logic [FIELD_W-1:0]  step;

  modport source (output valid, action, slot, delay_ticks, interval_ticks, one_shot, step,
                  input ready);
  modport sink (input valid, action, slot, delay_ticks, interval_ticks, one_shot, step,
                output ready);
endinterface

interface mst_out_if import mst_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               kind;
  logic [SLOT_W-1:0]  fired_slot;
  logic [FIELD_W-1:0] now_ticks;
  logic               last;

  modport source (output valid, kind, fired_slot, now_ticks, last, input ready);
  modport sink (input valid, kind, fired_slot, now_ticks, last, output ready);
endinterface

// ===== rtl/mst_slot_table.sv =====
// Slot table memory: delay, interval and running count of every timer slot.
// One write port per field group and one registered read port. Depends on mst_pkg.
module mst_slot_table import mst_pkg::*; (
  input  logic      clk,
  input  tbl_wr_t   wr,
  input  slot_idx_t rd_addr,
  output tbl_rd_t   rd_r
);

  tick_t delay_mem    [SLOTS];
  tick_t interval_mem [SLOTS];
  tick_t count_mem    [SLOTS];

  always_ff @(posedge clk) begin
    if (wr.cfg_en) begin
      delay_mem[wr.addr]    <= wr.delay;
      interval_mem[wr.addr] <= wr.interval;
    end
    if (wr.cnt_en) begin
      count_mem[wr.addr] <= wr.count;
    end
    rd_r.delay    <= delay_mem[rd_addr];
    rd_r.interval <= interval_mem[rd_addr];
    rd_r.count    <= count_mem[rd_addr];
  end

endmodule

// ===== rtl/mst_tick_alu.sv =====
// Shared count unit: adds the step to a slot count and compares against its limit.
// A carry out of the count width counts as reaching the limit. Depends on mst_pkg.
module mst_tick_alu import mst_pkg::*; (
  input  tick_t    count,
  input  tick_t    step,
  input  tick_t    limit,
  output alu_res_t res
);

  logic [TICK_BITS:0] sum;

  assign sum       = {1'b0, count} + {1'b0, step};
  assign res.hit   = sum[TICK_BITS] | (sum[TICK_BITS-1:0] >= limit);
  assign res.count = res.hit ? '0 : sum[TICK_BITS-1:0];

endmodule

// ===== rtl/multi_slot_software_timer_unit.sv =====
// Multi-slot software timer, top level.
// Depends on mst_pkg, mst_ifs, mst_slot_table and mst_tick_alu.
//
// Requests arrive as beats on in_ch. An arm beat loads a slot with its delay,
// interval and one-shot flag and clears its count; a free beat releases a slot.
// Neither produces a result beat. A tick beat advances the global tick count
// by its step and then walks the slot table, one slot per cycle through the
// shared count unit unless a stalled receiver holds the walk; when the step
// is zero the walk is skipped. The block takes no request during a tick.
// Each fired slot leaves as a result beat on out_ch in ascending slot order,
// and a closing beat with last set follows; every beat carries the new tick
// count. Results pass through a single output register: while the receiver
// holds ready low, the walk waits on the slot that fired and resumes when the
// register is taken. Reset clears all slot flags, the tick count and the
// output valid flag; the slot table contents are only used after an arm.
module multi_slot_software_timer_unit import mst_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  mst_in_if.sink   in_ch,
  mst_out_if.source out_ch
);

  typedef enum logic [1:0] {S_IDLE, S_PRIME, S_EVAL, S_CLOSE} state_t;

  state_t              state_r;
  slot_idx_t           idx_r;
  tick_t               step_r;
  tick_t               global_r;
  logic [SLOTS-1:0]    active_r;
  logic [SLOTS-1:0]    in_delay_r;
  logic [SLOTS-1:0]    one_shot_r;

  logic                out_valid_r;
  logic                out_kind_r;
  logic [SLOT_W-1:0]   out_slot_r;
  logic [FIELD_W-1:0]  out_now_r;
  logic                out_last_r;

  logic      in_acc;
  logic      slot_ok;
  slot_idx_t in_slot;
  tick_t     in_step;
  tick_t     in_delay;
  logic      out_free;
  logic      cur_active;
  logic      cur_in_delay;
  logic      cur_one_shot;
  tick_t     limit;
  logic      eval;
  logic      fire;
  logic      advance;
  logic      last_idx;
  logic      arm;
  logic      out_load;
  slot_idx_t rd_addr;
  tbl_wr_t   wr;
  tbl_rd_t   rd;
  alu_res_t  alu;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid & in_ch.ready;
  assign in_slot     = SLOT_IW'(in_ch.slot);
  assign slot_ok     = (int'(in_ch.slot) < SLOTS);
  assign in_step     = TICK_BITS'(in_ch.step);
  assign in_delay    = TICK_BITS'(in_ch.delay_ticks);
  assign arm         = in_acc & (in_ch.action == ACT_ARM) & slot_ok;

  assign out_free     = ~out_valid_r | out_ch.ready;
  assign cur_active   = active_r[idx_r];
  assign cur_in_delay = in_delay_r[idx_r];
  assign cur_one_shot = one_shot_r[idx_r];
  assign limit        = cur_in_delay ? rd.delay : rd.interval;

  assign eval     = (state_r == S_EVAL);
  assign fire     = eval & cur_active & ~cur_in_delay & alu.hit;
  assign advance  = eval & (~fire | out_free);
  assign last_idx = (idx_r == SLOT_IW'(SLOTS - 1));
  assign out_load = (fire & out_free) | ((state_r == S_CLOSE) & out_free);
  assign rd_addr  = advance ? slot_idx_t'(idx_r + 1'b1) : idx_r;

  assign wr.cfg_en   = arm;
  assign wr.cnt_en   = arm | (advance & cur_active);
  assign wr.addr     = (state_r == S_IDLE) ? in_slot : idx_r;
  assign wr.delay    = in_delay;
  assign wr.interval = TICK_BITS'(in_ch.interval_ticks);
  assign wr.count    = arm ? '0 : alu.count;

  mst_slot_table u_table (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_r    (rd)
  );

  mst_tick_alu u_alu (
    .count (rd.count),
    .step  (step_r),
    .limit (limit),
    .res   (alu)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      global_r    <= '0;
      active_r    <= '0;
      in_delay_r  <= '0;
      one_shot_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            unique case (in_ch.action)
              ACT_ARM: begin
                if (slot_ok) begin
                  active_r[in_slot]   <= 1'b1;
                  in_delay_r[in_slot] <= (in_delay != '0);
                  one_shot_r[in_slot] <= in_ch.one_shot;
                end
              end
              ACT_FREE: begin
                if (slot_ok) begin
                  active_r[in_slot] <= 1'b0;
                end
              end
              ACT_TICK: begin
                global_r <= global_r + in_step;
                idx_r    <= '0;
                state_r  <= (in_step != '0) ? S_PRIME : S_CLOSE;
              end
              default: begin
              end
            endcase
          end
        end
        S_PRIME: begin
          state_r <= S_EVAL;
        end
        S_EVAL: begin
          if (advance) begin
            if (cur_active && alu.hit) begin
              if (cur_in_delay) begin
                in_delay_r[idx_r] <= 1'b0;
              end else if (cur_one_shot) begin
                active_r[idx_r] <= 1'b0;
              end
            end
            idx_r <= slot_idx_t'(idx_r + 1'b1);
            if (last_idx) begin
              state_r <= S_CLOSE;
            end
          end
        end
        S_CLOSE: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && (in_ch.action == ACT_TICK)) begin
      step_r <= in_step;
    end
    if (out_load) begin
      out_kind_r <= fire ? KIND_FIRED : KIND_DONE;
      out_slot_r <= fire ? SLOT_W'(idx_r) : '0;
      out_now_r  <= FIELD_W'(global_r);
      out_last_r <= ~fire;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.kind       = out_kind_r;
  assign out_ch.fired_slot = out_slot_r;
  assign out_ch.now_ticks  = out_now_r;
  assign out_ch.last       = out_last_r;

  a_tick_starts_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_ch.action == ACT_TICK) && (in_step != '0)) |=> (state_r == S_PRIME))
    else $error("Tick with a nonzero step did not start the slot walk.");

  a_ticks_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_acc && (in_ch.action == ACT_TICK)) |=> (global_r == $past(global_r)))
    else $error("Global tick count changed without a tick beat.");

  a_one_shot_freed: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && out_free && cur_one_shot) |=> !active_r[$past(idx_r)])
    else $error("One-shot slot still active after firing.");

  a_load_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> ((state_r == S_EVAL) || (state_r == S_CLOSE)))
    else $error("Result register loaded outside the slot walk.");

endmodule

// ===== test/multi_slot_software_timer_unit_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the multi-slot software timer top level.
// Depends on mst_pkg, the channel interfaces in mst_ifs and the timer RTL, and
// checks every result beat of a tick against a predicted copy of the slot table.
module multi_slot_software_timer_unit_test;
  import mst_pkg::*;

  localparam logic [ACTION_W-1:0] ACT_NONE = 2'd3;
  localparam int DIRECTED_ITEMS = 22;
  localparam int RANDOM_ITEMS   = 128;
  localparam int QUIET_TAIL     = 30;
  localparam int HOLD_AFTER     = 40;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 40;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [SLOT_W-1:0]   slot;
    logic [FIELD_W-1:0]  delay_ticks;
    logic [FIELD_W-1:0]  interval_ticks;
    logic                one_shot;
    logic [FIELD_W-1:0]  step;
  } timer_req_t;

  typedef struct packed {
    logic               kind;
    logic [SLOT_W-1:0]  fired_slot;
    logic [FIELD_W-1:0] now_ticks;
    logic               last;
  } timer_event_t;

  logic clk;
  logic rst_n;

  mst_in_if  in_ch ();
  mst_out_if out_ch ();

  multi_slot_software_timer_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  timer_req_t   req_queue[$];
  timer_event_t due_events[$];

  bit    slot_armed [SLOTS];
  bit    slot_waiting [SLOTS];
  bit    slot_single [SLOTS];
  tick_t wait_len [SLOTS];
  tick_t period_len [SLOTS];
  tick_t elapsed [SLOTS];
  tick_t tick_now;

  bit          in_taken;
  int unsigned items_in;
  int unsigned errors;
  int unsigned send_gap;
  int unsigned recv_gap;
  int unsigned long_hold;
  bit          held_once;

  task automatic add_req(input logic [ACTION_W-1:0] action, input int unsigned slot,
                         input logic [FIELD_W-1:0] delay_ticks,
                         input logic [FIELD_W-1:0] interval_ticks,
                         input logic one_shot, input logic [FIELD_W-1:0] step);
    timer_req_t rq;
    rq.action         = action;
    rq.slot           = slot[SLOT_W-1:0];
    rq.delay_ticks    = delay_ticks;
    rq.interval_ticks = interval_ticks;
    rq.one_shot       = one_shot;
    rq.step           = step;
    req_queue.push_back(rq);
  endtask

  function automatic logic [FIELD_W-1:0] rand_span();
    int unsigned sel;
    sel = $urandom_range(0, 15);
    if (sel == 0) return $urandom();
    if (sel == 1) return 32'hFFFF_FFFF - $urandom_range(0, 3);
    if (sel < 5) return '0;
    return $urandom_range(1, 6);
  endfunction

  task automatic push_event(input logic kind, input int unsigned slot, input logic last);
    timer_event_t ev;
    ev.kind       = kind;
    ev.fired_slot = slot[SLOT_W-1:0];
    ev.now_ticks  = tick_now;
    ev.last       = last;
    due_events.push_back(ev);
  endtask

  // Applies one accepted request to the predicted slot table and queues the
  // result beats that a tick causes.
  task automatic advance_timers(input timer_req_t rq);
    tick_t sum;
    tick_t limit;
    bit    hit;
    int    i;
    case (rq.action)
      ACT_ARM: begin
        slot_armed[rq.slot]   = 1'b1;
        wait_len[rq.slot]     = rq.delay_ticks;
        period_len[rq.slot]   = rq.interval_ticks;
        slot_single[rq.slot]  = rq.one_shot;
        elapsed[rq.slot]      = '0;
        slot_waiting[rq.slot] = (rq.delay_ticks != 0);
      end
      ACT_FREE: begin
        slot_armed[rq.slot] = 1'b0;
      end
      ACT_TICK: begin
        if (rq.step != 0) begin
          tick_now = tick_now + rq.step;
          for (i = 0; i < SLOTS; i++) begin
            if (slot_armed[i]) begin
              limit = slot_waiting[i] ? wait_len[i] : period_len[i];
              sum = elapsed[i] + rq.step;
              hit = (sum < elapsed[i]) || (sum >= limit);
              elapsed[i] = sum;
              if (hit) begin
                elapsed[i] = '0;
                if (slot_waiting[i]) begin
                  slot_waiting[i] = 1'b0;
                end else begin
                  if (slot_single[i]) slot_armed[i] = 1'b0;
                  push_event(KIND_FIRED, i, 1'b0);
                end
              end
            end
          end
        end
        push_event(KIND_DONE, 0, 1'b1);
      end
      default: begin
      end
    endcase
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    timer_req_t   rq;
    timer_event_t got;
    timer_event_t want;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      rq.action         = in_ch.action;
      rq.slot           = in_ch.slot;
      rq.delay_ticks    = in_ch.delay_ticks;
      rq.interval_ticks = in_ch.interval_ticks;
      rq.one_shot       = in_ch.one_shot;
      rq.step           = in_ch.step;
      advance_timers(rq);
      req_queue.delete(0);
      items_in <= items_in + 1;
      in_taken <= 1'b1;
    end else begin
      in_taken <= 1'b0;
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.kind       = out_ch.kind;
      got.fired_slot = out_ch.fired_slot;
      got.now_ticks  = out_ch.now_ticks;
      got.last       = out_ch.last;
      if (due_events.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat kind=%0d slot=%0d now=%h last=%0d",
                 $time, got.kind, got.fired_slot, got.now_ticks, got.last);
      end else begin
        want = due_events.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t: expected k=%0d s=%0d n=%h l=%0d, got k=%0d s=%0d n=%h l=%0d",
                   $time, want.kind, want.fired_slot, want.now_ticks, want.last,
                   got.kind, got.fired_slot, got.now_ticks, got.last);
        end
      end
    end
  end

  // The sender keeps a beat steady until it is taken.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && !in_taken) begin
    end else if (send_gap > 0) begin
      in_ch.valid <= 1'b0;
      send_gap <= send_gap - 1;
    end else if (req_queue.size() >= QUIET_TAIL && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      send_gap <= $urandom_range(0, 17);
    end else if (req_queue.size() > 0) begin
      in_ch.valid          <= 1'b1;
      in_ch.action         <= req_queue[0].action;
      in_ch.slot           <= req_queue[0].slot;
      in_ch.delay_ticks    <= req_queue[0].delay_ticks;
      in_ch.interval_ticks <= req_queue[0].interval_ticks;
      in_ch.one_shot       <= req_queue[0].one_shot;
      in_ch.step           <= req_queue[0].step;
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (!held_once && items_in >= HOLD_AFTER) begin
      held_once <= 1'b1;
      long_hold <= HOLD_CYCLES - 1;
      out_ch.ready <= 1'b0;
    end else if (long_hold > 0) begin
      long_hold <= long_hold - 1;
      out_ch.ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap <= recv_gap - 1;
      out_ch.ready <= 1'b0;
    end else if (req_queue.size() >= QUIET_TAIL && $urandom_range(0, 6) == 0) begin
      recv_gap <= $urandom_range(0, 17);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  initial begin
    int unsigned pick;
    int          s;
    rst_n = 1'b0;
    in_taken = 1'b0;
    items_in = 0;
    errors = 0;
    send_gap = 0;
    recv_gap = 0;
    long_hold = 0;
    held_once = 1'b0;
    tick_now = '0;
    for (s = 0; s < SLOTS; s++) begin
      slot_armed[s]   = 1'b0;
      slot_waiting[s] = 1'b0;
      slot_single[s]  = 1'b0;
      wait_len[s]     = '0;
      period_len[s]   = '0;
      elapsed[s]      = '0;
    end
    in_ch.valid = 1'b0;
    in_ch.action = ACT_TICK;
    in_ch.slot = '0;
    in_ch.delay_ticks = '0;
    in_ch.interval_ticks = '0;
    in_ch.one_shot = 1'b0;
    in_ch.step = '0;
    out_ch.ready = 1'b0;

    // Directed part: empty ticks, ignored requests, zero interval, delays,
    // one-shot release, count carry, tick count wrap and re-arming.
    add_req(ACT_TICK, 0, $urandom(), $urandom(), 1'b1, 32'd0);
    add_req(ACT_TICK, 9, $urandom(), $urandom(), 1'b0, 32'd1);
    add_req(ACT_FREE, 5, $urandom(), $urandom(), 1'b1, $urandom());
    add_req(ACT_NONE, 15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
    add_req(ACT_ARM, 0, 32'd0, 32'd0, 1'b0, $urandom());
    add_req(ACT_ARM, 15, 32'd2, 32'd3, 1'b1, $urandom());
    add_req(ACT_ARM, 7, 32'd0, 32'hFFFF_FFFF, 1'b0, $urandom());
    add_req(ACT_TICK, 3, $urandom(), $urandom(), 1'b1, 32'd0);
    add_req(ACT_TICK, 0, $urandom(), $urandom(), 1'b0, 32'd1);
    add_req(ACT_TICK, 0, $urandom(), $urandom(), 1'b0, 32'd1);
    add_req(ACT_TICK, 0, $urandom(), $urandom(), 1'b0, 32'hFFFF_FFFF);
    add_req(ACT_ARM, 0, 32'hFFFF_FFFF, 32'd1, 1'b1, $urandom());
    add_req(ACT_TICK, 0, $urandom(), $urandom(), 1'b0, 32'h8000_0000);
    add_req(ACT_TICK, 0, $urandom(), $urandom(), 1'b0, 32'h8000_0000);
    add_req(ACT_FREE, 7, $urandom(), $urandom(), 1'b0, $urandom());
    add_req(ACT_FREE, 7, $urandom(), $urandom(), 1'b1, $urandom());
    add_req(ACT_ARM, 15, 32'd0, 32'd2, 1'b0, 32'hFFFF_FFFF);
    add_req(ACT_TICK, 0, $urandom(), $urandom(), 1'b0, 32'd2);
    add_req(ACT_ARM, 10, 32'd5, 32'd0, 1'b1, 32'h5555_AAAA);
    add_req(ACT_TICK, 6, 32'hAAAA_5555, 32'h5555_AAAA, 1'b1, 32'd7);
    add_req(ACT_NONE, 2, $urandom(), $urandom(), 1'b0, $urandom());
    add_req(ACT_TICK, 0, $urandom(), $urandom(), 1'b0, 32'd3);

    // Random part: mostly arms and ticks with small spans so that slots fire
    // often, with frees, ignored requests and whole-table fills mixed in.
    pick = 99;
    while (req_queue.size() < DIRECTED_ITEMS + RANDOM_ITEMS) begin
      if (pick >= 97) begin
        for (s = 0; s < SLOTS; s++)
          add_req(ACT_ARM, s, 32'd0, $urandom_range(0, 1), 1'($urandom_range(0, 1)),
                  $urandom());
        add_req(ACT_TICK, $urandom(), $urandom(), $urandom(), 1'($urandom_range(0, 1)),
                32'd1);
      end else if (pick < 35) begin
        add_req(ACT_ARM, $urandom_range(0, 15), rand_span(), rand_span(),
                1'($urandom_range(0, 1)), $urandom());
      end else if (pick < 75) begin
        add_req(ACT_TICK, $urandom(), $urandom(), $urandom(), 1'($urandom_range(0, 1)),
                rand_span());
      end else if (pick < 91) begin
        add_req(ACT_FREE, $urandom_range(0, 15), $urandom(), $urandom(),
                1'($urandom_range(0, 1)), $urandom());
      end else begin
        add_req(ACT_NONE, $urandom(), $urandom(), $urandom(), 1'($urandom_range(0, 1)),
                $urandom());
      end
      pick = $urandom_range(0, 99);
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (req_queue.size() != 0 || due_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && due_events.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
